// ----- rtl/whr_pkg.sv -----
// ----------------------------------------------------------------------------
// whr_pkg: shared types and constants for the windowed heart rate block
// Payload structs, configuration layout, controller states, datapath commands.
// ----------------------------------------------------------------------------
package whr_pkg;

	localparam int VAL_W = 40;
	localparam int XW    = 56;
	localparam int DIV_W = 33;
	localparam int CNT_W = 6;

	localparam int ROOT_STEPS = 16;

	localparam int GRAV_MILLI  = 94;
	localparam int BAND_MILLI  = 460;
	localparam int ENV_MILLI   = 16;
	localparam int FLOOR_MILLI = 800;
	localparam int THR_MILLI   = 2200;

	localparam int SEC_PER_MIN = 60;
	localparam int BPM_MIN     = 40;
	localparam int BPM_MAX     = 180;

	localparam logic signed [XW-1:0] SAT_MAX = XW'(64'sh0000_007F_FFFF_FFFF);
	localparam logic signed [XW-1:0] SAT_MIN = -XW'(64'sh0000_0080_0000_0000);

	typedef struct packed {
		logic signed [15:0] accel_x;
		logic signed [15:0] accel_y;
		logic signed [15:0] accel_z;
		logic               restart;
	} sample_t;

	typedef struct packed {
		logic       average_ready;
		logic [7:0] beats_per_minute;
		logic       rate_valid;
		logic       beat_found;
	} result_t;

	typedef enum logic [1:0] {
		REG_SAMPLE_RATE,
		REG_WINDOW,
		REG_MIN_BEAT,
		REG_MAX_BEAT
	} reg_idx_t;

	typedef struct packed {
		logic [9:0]  sample_rate_hz;
		logic [15:0] window_samples;
		logic [15:0] min_beat_samples;
		logic [15:0] max_beat_samples;
	} cfg_t;

	typedef enum logic [4:0] {
		ST_IDLE,
		ST_SQ_X,
		ST_SQ_Y,
		ST_SQ_Z,
		ST_SQ_SUM,
		ST_ROOT,
		ST_MAG,
		ST_MC_HI,
		ST_MC_LO,
		ST_MC_SUM,
		ST_MC_APPLY,
		ST_PEAK,
		ST_CHK,
		ST_DIV1,
		ST_AVG,
		ST_DIV2,
		ST_BPM,
		ST_DONE
	} state_t;

	typedef enum logic [4:0] {
		OP_NONE,
		OP_LOAD,
		OP_SQ_X,
		OP_SQ_Y,
		OP_SQ_Z,
		OP_SQ_SUM,
		OP_ROOT,
		OP_MAG,
		OP_MC_HI,
		OP_MC_LO,
		OP_MC_SUM,
		OP_MC_APPLY,
		OP_PEAK,
		OP_CHK,
		OP_DIV,
		OP_AVG,
		OP_BPM,
		OP_OUT
	} op_t;

	typedef enum logic [1:0] {
		FLT_GRAV,
		FLT_BAND,
		FLT_ENV,
		FLT_THR
	} flt_t;

	typedef struct packed {
		op_t  op;
		flt_t flt;
	} cmd_t;

	typedef struct packed {
		logic close;
		logic pub_go;
		logic avg_nz;
	} status_t;

endpackage

// ----- rtl/windowed_heart_rate_from_accel.sv -----
// ----------------------------------------------------------------------------
// windowed_heart_rate_from_accel: heart rate from a three-axis accelerometer
// Magnitude, gravity/band/envelope filters, beat picking, windowed BPM.
// ----------------------------------------------------------------------------
// One sample is taken at a time. From acceptance to its result a sample goes
// through squaring on the shared multiplier, the bit-serial square root, the
// magnitude, four filter updates on the same multiplier, the peak test, the
// window check and the output load. The next sample is accepted after the
// output load, once the block is back in idle. A sample that closes a window
// with enough intervals and a recent beat also runs the two bit-serial
// divisions (average interval, then BPM, the latter only for a nonzero
// average) before the output load. The result sits in an output register,
// so a stalled result only holds the next sample at the end of its work.
module windowed_heart_rate_from_accel #(
	parameter int unsigned FRACTION_BITS = 16
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             sample_valid,
	output logic             sample_ready,
	input  whr_pkg::sample_t sample,
	output logic             result_valid,
	input  logic             result_ready,
	output whr_pkg::result_t result,
	input  logic             cfg_we,
	input  logic [1:0]       cfg_index,
	input  logic [15:0]      cfg_data
);
	import whr_pkg::*;

	cfg_t    cfg_q;
	cmd_t    cmd;
	status_t sts;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.sample_rate_hz   <= 10'd25;
			cfg_q.window_samples   <= 16'd375;
			cfg_q.min_beat_samples <= 16'd4;
			cfg_q.max_beat_samples <= 16'd62;
		end else if (cfg_we) begin
			case (reg_idx_t'(cfg_index))
				REG_SAMPLE_RATE: cfg_q.sample_rate_hz   <= cfg_data[9:0];
				REG_WINDOW:      cfg_q.window_samples   <= cfg_data;
				REG_MIN_BEAT:    cfg_q.min_beat_samples <= cfg_data;
				REG_MAX_BEAT:    cfg_q.max_beat_samples <= cfg_data;
				default: ;
			endcase
		end
	end

	whr_ctrl u_ctrl (
		.clk          (clk),
		.arst_n       (arst_n),
		.sample_valid (sample_valid),
		.sample_ready (sample_ready),
		.result_valid (result_valid),
		.result_ready (result_ready),
		.sts          (sts),
		.cmd          (cmd)
	);

	whr_datapath #(
		.FRACTION_BITS (FRACTION_BITS)
	) u_datapath (
		.clk    (clk),
		.arst_n (arst_n),
		.cmd    (cmd),
		.cfg    (cfg_q),
		.sample (sample),
		.result (result),
		.sts    (sts)
	);

	a_busy_after_accept: assert property (@(posedge clk) disable iff (!arst_n)
		(sample_valid && sample_ready) |=> !sample_ready)
		else $error("sample accepted while previous transaction in progress");

	a_rate_in_range: assert property (@(posedge clk) disable iff (!arst_n)
		(result_valid && result.rate_valid) |->
		(result.beats_per_minute >= 8'(BPM_MIN) && result.beats_per_minute <= 8'(BPM_MAX)))
		else $error("valid rate outside accepted range");

	a_no_result_while_idle: assert property (@(posedge clk) disable iff (!arst_n)
		(sample_ready && !result_valid) |=> !result_valid)
		else $error("result appeared without an accepted sample");

endmodule

// ----- rtl/whr_ctrl.sv -----
// ----------------------------------------------------------------------------
// whr_ctrl: sequencer for the heart rate datapath
// Steps one sample through square sum, root, filters, peak test and publish.
// ----------------------------------------------------------------------------
module whr_ctrl (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             sample_valid,
	output logic             sample_ready,
	output logic             result_valid,
	input  logic             result_ready,
	input  whr_pkg::status_t sts,
	output whr_pkg::cmd_t    cmd
);
	import whr_pkg::*;

	state_t            state_q, state_nx;
	flt_t              flt_q, flt_nx;
	logic [CNT_W-1:0]  cnt_q, cnt_nx;
	logic              out_valid_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			flt_q       <= FLT_GRAV;
			cnt_q       <= '0;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_nx;
			flt_q   <= flt_nx;
			cnt_q   <= cnt_nx;
			if (cmd.op == OP_OUT) begin
				out_valid_q <= 1'b1;
			end else if (result_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_comb begin
		state_nx     = state_q;
		flt_nx       = flt_q;
		cnt_nx       = cnt_q;
		cmd.op       = OP_NONE;
		cmd.flt      = flt_q;
		sample_ready = 1'b0;
		case (state_q)
			ST_IDLE: begin
				sample_ready = 1'b1;
				if (sample_valid) begin
					cmd.op   = OP_LOAD;
					state_nx = ST_SQ_X;
				end
			end
			ST_SQ_X: begin
				cmd.op   = OP_SQ_X;
				state_nx = ST_SQ_Y;
			end
			ST_SQ_Y: begin
				cmd.op   = OP_SQ_Y;
				state_nx = ST_SQ_Z;
			end
			ST_SQ_Z: begin
				cmd.op   = OP_SQ_Z;
				state_nx = ST_SQ_SUM;
			end
			ST_SQ_SUM: begin
				cmd.op   = OP_SQ_SUM;
				cnt_nx   = '0;
				state_nx = ST_ROOT;
			end
			ST_ROOT: begin
				cmd.op = OP_ROOT;
				if (cnt_q == CNT_W'(ROOT_STEPS - 1)) begin
					state_nx = ST_MAG;
				end else begin
					cnt_nx = cnt_q + 1'b1;
				end
			end
			ST_MAG: begin
				cmd.op   = OP_MAG;
				flt_nx   = FLT_GRAV;
				state_nx = ST_MC_HI;
			end
			ST_MC_HI: begin
				cmd.op   = OP_MC_HI;
				state_nx = ST_MC_LO;
			end
			ST_MC_LO: begin
				cmd.op   = OP_MC_LO;
				state_nx = ST_MC_SUM;
			end
			ST_MC_SUM: begin
				cmd.op   = OP_MC_SUM;
				state_nx = ST_MC_APPLY;
			end
			ST_MC_APPLY: begin
				cmd.op = OP_MC_APPLY;
				if (flt_q == FLT_THR) begin
					state_nx = ST_PEAK;
				end else begin
					flt_nx   = flt_t'(flt_q + 2'd1);
					state_nx = ST_MC_HI;
				end
			end
			ST_PEAK: begin
				cmd.op   = OP_PEAK;
				state_nx = ST_CHK;
			end
			ST_CHK: begin
				cmd.op = OP_CHK;
				cnt_nx = '0;
				if (sts.close && sts.pub_go) begin
					state_nx = ST_DIV1;
				end else begin
					state_nx = ST_DONE;
				end
			end
			ST_DIV1: begin
				cmd.op = OP_DIV;
				if (cnt_q == CNT_W'(DIV_W - 1)) begin
					state_nx = ST_AVG;
				end else begin
					cnt_nx = cnt_q + 1'b1;
				end
			end
			ST_AVG: begin
				cmd.op = OP_AVG;
				cnt_nx = '0;
				if (sts.avg_nz) begin
					state_nx = ST_DIV2;
				end else begin
					state_nx = ST_DONE;
				end
			end
			ST_DIV2: begin
				cmd.op = OP_DIV;
				if (cnt_q == CNT_W'(DIV_W - 1)) begin
					state_nx = ST_BPM;
				end else begin
					cnt_nx = cnt_q + 1'b1;
				end
			end
			ST_BPM: begin
				cmd.op   = OP_BPM;
				state_nx = ST_DONE;
			end
			ST_DONE: begin
				if (!out_valid_q || result_ready) begin
					cmd.op   = OP_OUT;
					state_nx = ST_IDLE;
				end
			end
			default: begin
				state_nx = ST_IDLE;
			end
		endcase
	end

	assign result_valid = out_valid_q;

endmodule

// ----- rtl/whr_datapath.sv -----
// ----------------------------------------------------------------------------
// whr_datapath: arithmetic and state for the heart rate block
// Shared multiplier, bit-serial root and divider, filters, beat and window logic.
// ----------------------------------------------------------------------------
module whr_datapath #(
	parameter int unsigned FRACTION_BITS = 16
) (
	input  logic             clk,
	input  logic             arst_n,
	input  whr_pkg::cmd_t    cmd,
	input  whr_pkg::cfg_t    cfg,
	input  whr_pkg::sample_t sample,
	output whr_pkg::result_t result,
	output whr_pkg::status_t sts
);
	import whr_pkg::*;

	localparam int F  = FRACTION_BITS;
	localparam int AW = (43 - F > F) ? 43 - F : F;
	localparam int BW = (F + 2 > 17) ? F + 2 : 17;
	localparam int PW = AW + BW;

	localparam logic [BW-1:0] C_GRAV = BW'(((64'(GRAV_MILLI) << F) + 64'd500) / 64'd1000);
	localparam logic [BW-1:0] C_BAND = BW'(((64'(BAND_MILLI) << F) + 64'd500) / 64'd1000);
	localparam logic [BW-1:0] C_ENV  = BW'(((64'(ENV_MILLI) << F) + 64'd500) / 64'd1000);
	localparam logic [BW-1:0] C_THR  = BW'(((64'(THR_MILLI) << F) + 64'd500) / 64'd1000);
	localparam logic signed [XW-1:0] THR_FLOOR =
		XW'(((64'(FLOOR_MILLI) << F) + 64'd500) / 64'd1000);
	localparam logic signed [VAL_W-1:0] ONE_FX = VAL_W'(1) << F;
	localparam logic [XW-1:0] HALF = XW'(1) << (F - 1);

	function automatic logic signed [VAL_W-1:0] sat40(input logic signed [XW-1:0] v);
		logic signed [VAL_W-1:0] r;
		if (v > SAT_MAX) begin
			r = VAL_W'(SAT_MAX);
		end else if (v < SAT_MIN) begin
			r = VAL_W'(SAT_MIN);
		end else begin
			r = VAL_W'(v);
		end
		return r;
	endfunction

	// beat and window state
	logic [31:0]             si_q, lb_q, tot_q;
	logic [15:0]             tally_q, wp_q;
	logic signed [VAL_W-1:0] grav_q, band_q, env_q, d1_q, d2_q;
	logic                    seen_q, ok_q;
	logic [7:0]              rate_q;

	// working registers
	sample_t                 smp_q;
	logic [PW-1:0]           prod_q;
	logic [31:0]             sq_q, v_q, res_q, bit_q;
	logic signed [VAL_W-1:0] mag_q;
	logic [F-1:0]            lo_q;
	logic                    neg_q;
	logic [XW-1:0]           hprod_q;
	logic signed [XW-1:0]    mc_q, thr2_q;
	logic                    beat_q, close_q;
	logic [DIV_W:0]          rem_q;
	logic [DIV_W-1:0]        quo_q, dvs_q;
	result_t                 res_out_q;

	logic signed [16:0]      sel_s;
	logic [16:0]             sel_abs;
	logic signed [XW-1:0]    hp, absf, d, thr, mc_s, mag_x;
	logic [XW-1:0]           m, mc_r;
	logic                    neg;
	logic [AW-1:0]           mul_a;
	logic [BW-1:0]           mul_b, coef;
	logic [32:0]             rt_t;
	logic                    rt_ge;
	logic signed [VAL_W-1:0] mag_nx;
	logic [31:0]             gap;
	logic                    peak, take, add;
	logic [15:0]             wp_nx;
	logic [DIV_W:0]          rem_sh;
	logic                    div_ge;

	always_comb begin
		case (cmd.op)
			OP_SQ_Y: sel_s = 17'(smp_q.accel_y);
			OP_SQ_Z: sel_s = 17'(smp_q.accel_z);
			default: sel_s = 17'(smp_q.accel_x);
		endcase
		sel_abs = (sel_s < 0) ? 17'(-sel_s) : 17'(sel_s);

		hp   = XW'(mag_q) - XW'(grav_q);
		absf = (band_q < 0) ? -XW'(band_q) : XW'(band_q);
		case (cmd.flt)
			FLT_GRAV: begin
				d    = XW'(mag_q) - XW'(grav_q);
				coef = C_GRAV;
			end
			FLT_BAND: begin
				d    = hp - XW'(band_q);
				coef = C_BAND;
			end
			FLT_ENV: begin
				d    = absf - XW'(env_q);
				coef = C_ENV;
			end
			default: begin
				d    = XW'(env_q);
				coef = C_THR;
			end
		endcase
		neg = d < 0;
		m   = neg ? $unsigned(-d) : $unsigned(d);

		case (cmd.op)
			OP_MC_HI: begin
				mul_a = AW'(m >> F);
				mul_b = coef;
			end
			OP_MC_LO: begin
				mul_a = AW'(lo_q);
				mul_b = coef;
			end
			default: begin
				mul_a = AW'(sel_abs);
				mul_b = BW'(sel_abs);
			end
		endcase

		mc_r = hprod_q + ((XW'(prod_q) + HALF) >> F);
		mc_s = neg_q ? -$signed(mc_r) : $signed(mc_r);

		rt_t  = {1'b0, res_q} + {1'b0, bit_q};
		rt_ge = {1'b0, v_q} >= rt_t;

		mag_x  = XW'(res_q[15:0]) << F;
		mag_nx = sat40(mag_x);

		thr   = (thr2_q > THR_FLOOR) ? thr2_q : THR_FLOOR;
		peak  = (d1_q > d2_q) && (d1_q >= band_q) && (XW'(d1_q) > thr);
		gap   = si_q - lb_q;
		take  = peak && (!seen_q || gap >= 32'(cfg.min_beat_samples));
		add   = take && seen_q && gap <= 32'(cfg.max_beat_samples);
		wp_nx = wp_q + 16'd1;

		rem_sh = {rem_q[DIV_W-1:0], quo_q[DIV_W-1]};
		div_ge = rem_sh >= {1'b0, dvs_q};
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			si_q    <= '0;
			lb_q    <= '0;
			tot_q   <= '0;
			tally_q <= '0;
			wp_q    <= '0;
			grav_q  <= '0;
			band_q  <= '0;
			env_q   <= ONE_FX;
			d1_q    <= '0;
			d2_q    <= '0;
			seen_q  <= 1'b0;
			rate_q  <= '0;
			ok_q    <= 1'b0;
		end else begin
			case (cmd.op)
				OP_LOAD: begin
					if (sample.restart) begin
						si_q    <= '0;
						lb_q    <= '0;
						tot_q   <= '0;
						tally_q <= '0;
						wp_q    <= '0;
						grav_q  <= '0;
						band_q  <= '0;
						env_q   <= ONE_FX;
						d1_q    <= '0;
						d2_q    <= '0;
						seen_q  <= 1'b0;
						rate_q  <= '0;
						ok_q    <= 1'b0;
					end
				end
				OP_MAG: begin
					if (grav_q == '0) begin
						grav_q <= mag_nx;
					end
				end
				OP_MC_APPLY: begin
					case (cmd.flt)
						FLT_GRAV: grav_q <= sat40(XW'(grav_q) + mc_q);
						FLT_BAND: band_q <= sat40(XW'(band_q) + mc_q);
						FLT_ENV:  env_q  <= sat40(XW'(env_q) + mc_q);
						default: ;
					endcase
				end
				OP_PEAK: begin
					if (take) begin
						lb_q   <= si_q;
						seen_q <= 1'b1;
					end
					if (add) begin
						tot_q <= tot_q + gap;
						if (tally_q != 16'hFFFF) begin
							tally_q <= tally_q + 16'd1;
						end
					end
					d2_q <= d1_q;
					d1_q <= band_q;
					si_q <= si_q + 32'd1;
					wp_q <= wp_nx;
				end
				OP_CHK: begin
					if (close_q) begin
						ok_q    <= 1'b0;
						tot_q   <= '0;
						tally_q <= '0;
						wp_q    <= '0;
					end
				end
				OP_BPM: begin
					if (quo_q >= DIV_W'(BPM_MIN) && quo_q <= DIV_W'(BPM_MAX)) begin
						rate_q <= quo_q[7:0];
						ok_q   <= 1'b1;
					end
				end
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		prod_q <= PW'(mul_a) * PW'(mul_b);
		case (cmd.op)
			OP_LOAD: smp_q <= sample;
			OP_SQ_Y: sq_q <= prod_q[31:0];
			OP_SQ_Z: sq_q <= sq_q + prod_q[31:0];
			OP_SQ_SUM: begin
				v_q   <= sq_q + prod_q[31:0];
				res_q <= '0;
				bit_q <= 32'h4000_0000;
			end
			OP_ROOT: begin
				if (rt_ge) begin
					v_q   <= v_q - rt_t[31:0];
					res_q <= (res_q >> 1) + bit_q;
				end else begin
					res_q <= res_q >> 1;
				end
				bit_q <= bit_q >> 2;
			end
			OP_MAG: mag_q <= mag_nx;
			OP_MC_HI: begin
				lo_q  <= m[F-1:0];
				neg_q <= neg;
			end
			OP_MC_LO: hprod_q <= XW'(prod_q);
			OP_MC_SUM: mc_q <= mc_s;
			OP_MC_APPLY: begin
				if (cmd.flt == FLT_THR) begin
					thr2_q <= mc_q;
				end
			end
			OP_PEAK: begin
				beat_q  <= take;
				close_q <= wp_nx >= cfg.window_samples;
			end
			OP_CHK: begin
				rem_q <= '0;
				quo_q <= DIV_W'(tot_q) + DIV_W'(tally_q >> 1);
				dvs_q <= DIV_W'(tally_q);
			end
			OP_DIV: begin
				if (div_ge) begin
					rem_q <= rem_sh - {1'b0, dvs_q};
					quo_q <= {quo_q[DIV_W-2:0], 1'b1};
				end else begin
					rem_q <= rem_sh;
					quo_q <= {quo_q[DIV_W-2:0], 1'b0};
				end
			end
			OP_AVG: begin
				rem_q <= '0;
				quo_q <= DIV_W'(cfg.sample_rate_hz) * DIV_W'(SEC_PER_MIN) + (quo_q >> 1);
				dvs_q <= quo_q;
			end
			OP_OUT: begin
				res_out_q.average_ready    <= close_q;
				res_out_q.beats_per_minute <= rate_q;
				res_out_q.rate_valid       <= ok_q;
				res_out_q.beat_found       <= beat_q;
			end
			default: ;
		endcase
	end

	assign sts.close  = close_q;
	assign sts.pub_go = seen_q && (gap <= {15'd0, cfg.max_beat_samples, 1'b0})
		&& (tally_q >= 16'd2);
	assign sts.avg_nz = quo_q != '0;
	assign result     = res_out_q;

endmodule

// ----- bench/whr_checker.sv -----
// ----------------------------------------------------------------------------
// whr_checker: result predictor and scoreboard for the heart rate block
// Tracks register writes, predicts one result per accepted sample from a
// fixed-point model of the filters and beat picking, and compares each
// accepted result field by field with the oldest prediction.
// ----------------------------------------------------------------------------
module whr_checker
	import whr_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  logic        sample_valid,
	input  logic        sample_ready,
	input  sample_t     sample,
	input  logic        result_valid,
	input  logic        result_ready,
	input  result_t     result,
	input  logic        cfg_we,
	input  logic [1:0]  cfg_index,
	input  logic [15:0] cfg_data,
	output int          errors,
	output int          pending
);
	timeunit 1ns;
	timeprecision 1ps;

	localparam int FB = 16;
	localparam longint LIM_HI = 64'sh7F_FFFF_FFFF;
	localparam longint LIM_LO = -64'sh80_0000_0000;

	logic [9:0]  rate_hz;
	logic [15:0] win_len, min_gap, max_gap;

	int unsigned idx, last_beat, gap_sum;
	int unsigned gap_cnt, win_pos;
	longint      grav, band, env, band_d1, band_d2;
	bit          seen, ok;
	logic [7:0]  bpm_held;

	result_t expected_q[$];

	function automatic longint coef(int milli);
		return ((longint'(milli) << FB) + 500) / 1000;
	endfunction

	function automatic longint clamp40(longint v);
		if (v > LIM_HI)
			return LIM_HI;
		if (v < LIM_LO)
			return LIM_LO;
		return v;
	endfunction

	function automatic longint scale(longint d, longint c);
		bit     neg;
		longint m, hi, lo, r;
		neg = d < 0;
		m = neg ? -d : d;
		hi = m >>> FB;
		lo = m & ((longint'(1) << FB) - 1);
		r = hi * c + ((lo * c + (longint'(1) << (FB - 1))) >>> FB);
		return neg ? -r : r;
	endfunction

	function automatic longint root(longint unsigned v);
		longint unsigned res, b;
		res = 0;
		b = longint'(1) << 34;
		while (b > v)
			b = b >> 2;
		while (b != 0) begin
			if (v >= res + b) begin
				v = v - (res + b);
				res = (res >> 1) + b;
			end else begin
				res = res >> 1;
			end
			b = b >> 2;
		end
		return longint'(res);
	endfunction

	function automatic void clear_track();
		idx = 0;
		last_beat = 0;
		gap_sum = 0;
		gap_cnt = 0;
		win_pos = 0;
		grav = 0;
		band = 0;
		env = longint'(1) << FB;
		band_d1 = 0;
		band_d2 = 0;
		seen = 0;
		ok = 0;
		bpm_held = 0;
	endfunction

	function automatic void close_window();
		bit              recent;
		longint unsigned avg, bpm;
		recent = seen && ((idx - last_beat) <= 32'(max_gap) * 2);
		ok = 0;
		if (recent && gap_cnt >= 2) begin
			avg = (longint'(gap_sum) + gap_cnt / 2) / gap_cnt;
			if (avg != 0) begin
				bpm = (longint'(rate_hz) * SEC_PER_MIN + avg / 2) / avg;
				if (bpm >= BPM_MIN && bpm <= BPM_MAX) begin
					bpm_held = bpm[7:0];
					ok = 1;
				end
			end
		end
		gap_sum = 0;
		gap_cnt = 0;
		win_pos = 0;
	endfunction

	function automatic result_t heart_step(sample_t s);
		result_t         r;
		longint          x, y, z, mag, hp, absb, thr, thr2;
		longint unsigned sq;
		int unsigned     gap;
		r = '0;
		if (s.restart)
			clear_track();
		x = s.accel_x;
		y = s.accel_y;
		z = s.accel_z;
		sq = x * x + y * y + z * z;
		mag = clamp40(root(sq) << FB);
		if (grav == 0)
			grav = mag;
		grav = clamp40(grav + scale(mag - grav, coef(GRAV_MILLI)));
		hp = mag - grav;
		band = clamp40(band + scale(hp - band, coef(BAND_MILLI)));
		absb = band < 0 ? -band : band;
		env = clamp40(env + scale(absb - env, coef(ENV_MILLI)));
		thr = coef(FLOOR_MILLI);
		thr2 = scale(env, coef(THR_MILLI));
		if (thr2 > thr)
			thr = thr2;
		if (band_d1 > band_d2 && band_d1 >= band && band_d1 > thr) begin
			gap = idx - last_beat;
			if (!seen || gap >= min_gap) begin
				if (seen && gap <= max_gap) begin
					gap_sum = gap_sum + gap;
					if (gap_cnt < 16'hFFFF)
						gap_cnt++;
				end
				last_beat = idx;
				seen = 1;
				r.beat_found = 1;
			end
		end
		band_d2 = band_d1;
		band_d1 = band;
		idx = idx + 1;
		win_pos = (win_pos + 1) & 16'hFFFF;
		if (win_pos >= win_len) begin
			close_window();
			r.average_ready = 1;
		end
		r.beats_per_minute = bpm_held;
		r.rate_valid = ok;
		return r;
	endfunction

	always @(posedge clk or negedge arst_n) begin
		result_t e;
		if (!arst_n) begin
			rate_hz = 10'd25;
			win_len = 16'd375;
			min_gap = 16'd4;
			max_gap = 16'd62;
			clear_track();
			expected_q.delete();
			errors = 0;
			pending = 0;
		end else begin
			if (cfg_we) begin
				case (reg_idx_t'(cfg_index))
					REG_SAMPLE_RATE: rate_hz = cfg_data[9:0];
					REG_WINDOW:      win_len = cfg_data;
					REG_MIN_BEAT:    min_gap = cfg_data;
					REG_MAX_BEAT:    max_gap = cfg_data;
					default: ;
				endcase
			end
			if (result_valid && result_ready) begin
				if (expected_q.size() == 0) begin
					$error("result transaction with no expectation: %p", result);
					errors++;
				end else begin
					e = expected_q.pop_front();
					if (result.average_ready !== e.average_ready) begin
						$error("average_ready exp %0d got %0d", e.average_ready,
							result.average_ready);
						errors++;
					end
					if (result.beats_per_minute !== e.beats_per_minute) begin
						$error("beats_per_minute exp %0d got %0d", e.beats_per_minute,
							result.beats_per_minute);
						errors++;
					end
					if (result.rate_valid !== e.rate_valid) begin
						$error("rate_valid exp %0d got %0d", e.rate_valid,
							result.rate_valid);
						errors++;
					end
					if (result.beat_found !== e.beat_found) begin
						$error("beat_found exp %0d got %0d", e.beat_found,
							result.beat_found);
						errors++;
					end
				end
			end
			if (sample_valid && sample_ready)
				expected_q.push_back(heart_step(sample));
			pending = expected_q.size();
		end
	end

endmodule

// ----- bench/tb_top.sv -----
// ----------------------------------------------------------------------------
// tb_top: testbench for the windowed heart rate block
// Drives directed extremes, then phases of synthetic heartbeat traces mixed
// with noise and restarts under several register settings, with random
// stalls on both channels; the checker predicts and compares every result.
// ----------------------------------------------------------------------------
module tb_top;
	import whr_pkg::*;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int IDLE_LIMIT = 20000;
	localparam int SAMPLE_W   = $bits(sample_t);

	logic        clk = 0;
	logic        arst_n = 0;
	logic        sample_valid = 0;
	logic        sample_ready;
	sample_t     sample = '0;
	logic        result_valid;
	logic        result_ready = 0;
	result_t     result;
	logic        cfg_we = 0;
	logic [1:0]  cfg_index = REG_SAMPLE_RATE;
	logic [15:0] cfg_data = '0;
	int          errors, pending;

	int sent = 0;
	bit calm = 0;
	int period, amp, base_g, beat_k;

	always #6 clk = ~clk;

	windowed_heart_rate_from_accel dut (
		.clk, .arst_n, .sample_valid, .sample_ready, .sample,
		.result_valid, .result_ready, .result, .cfg_we, .cfg_index, .cfg_data
	);

	whr_checker chk (
		.clk, .arst_n, .sample_valid, .sample_ready, .sample,
		.result_valid, .result_ready, .result, .cfg_we, .cfg_index, .cfg_data,
		.errors, .pending
	);

	function automatic int pick_gap();
		int r;
		if (calm)
			return 0;
		r = $urandom_range(0, 15);
		if (r < 7)
			return 0;
		if (r < 15)
			return $urandom_range(1, 4);
		return $urandom_range(10, 80);
	endfunction

	task automatic send(sample_t s);
		int gap;
		gap = pick_gap();
		if (gap > 0) begin
			sample_valid <= 0;
			repeat (gap) @(posedge clk);
		end
		sample <= s;
		sample_valid <= 1;
		@(posedge clk);
		while (!sample_ready)
			@(posedge clk);
		sent++;
	endtask

	task automatic write_reg(reg_idx_t r, logic [15:0] d);
		cfg_we <= 1;
		cfg_index <= r;
		cfg_data <= d;
		@(posedge clk);
	endtask

	task automatic settle();
		sample_valid <= 0;
		@(posedge clk);
		while (pending != 0)
			@(posedge clk);
		repeat (130) @(posedge clk);
	endtask

	function automatic sample_t raw(int x, int y, int z, bit rs);
		sample_t s;
		s.accel_x = 16'(x);
		s.accel_y = 16'(y);
		s.accel_z = 16'(z);
		s.restart = rs;
		return s;
	endfunction

	function automatic void new_trace();
		period = $urandom_range(5, 40);
		amp = $urandom_range(50, 4000);
		base_g = $urandom_range(500, 16000);
		beat_k = 0;
	endfunction

	function automatic sample_t pulse_item();
		int z;
		z = base_g + $urandom_range(0, 40) - 20;
		if (beat_k % period == 0)
			z = z + amp;
		beat_k++;
		return raw($urandom_range(0, 60) - 30, $urandom_range(0, 60) - 30, z, 0);
	endfunction

	task automatic run_phase(int n);
		int r;
		sample_t s;
		new_trace();
		repeat (n) begin
			r = $urandom_range(0, 99);
			if (r < 82) begin
				s = pulse_item();
			end else if (r < 92) begin
				s = sample_t'(SAMPLE_W'({$urandom, $urandom}));
				s.restart = ($urandom_range(0, 9) == 0);
			end else if (r < 96) begin
				new_trace();
				s = pulse_item();
				s.restart = 1;
			end else begin
				period = $urandom_range(2, 70);
				s = pulse_item();
			end
			send(s);
		end
	endtask

	initial begin : receiver
		bit held_long;
		held_long = 0;
		wait (arst_n);
		forever begin
			@(posedge clk);
			if (!held_long && sent >= 400) begin
				held_long = 1;
				result_ready <= 0;
				repeat (700) @(posedge clk);
			end else if (!calm && $urandom_range(0, 3) == 0) begin
				result_ready <= 0;
				repeat (1 + pick_gap()) @(posedge clk);
			end
			result_ready <= 1;
		end
	end

	initial begin : watchdog
		int idle;
		idle = 0;
		forever begin
			@(posedge clk);
			if ((sample_valid && sample_ready) || (result_valid && result_ready))
				idle = 0;
			else
				idle++;
			if (idle >= IDLE_LIMIT) begin
				$display("FAILURE");
				$finish;
			end
		end
	end

	initial begin : stimulus
		logic [15:0] setting[4];
		repeat (5) @(posedge clk);
		arst_n <= 1;
		@(posedge clk);

		send(raw(-32768, -32768, -32768, 0));
		send(raw(32767, 32767, 32767, 0));
		send(raw(0, 0, 0, 0));
		send(raw(0, 0, 0, 0));
		send(raw(-32768, 32767, 0, 0));
		send(raw(0, 0, 4096, 1));
		send(raw(1, -1, 1, 0));
		base_g = 4096;
		amp = 2000;
		period = 6;
		beat_k = 0;
		repeat (16)
			send(pulse_item());
		settle();

		for (int p = 0; p < 6; p++) begin
			case (p)
				0: setting = '{16'd25, 16'd60, 16'd4, 16'd62};
				1: setting = '{16'd1023, 16'd1, 16'd0, 16'd65535};
				2: setting = '{16'd1, 16'd65535, 16'd65535, 16'd1};
				3: setting = '{16'd0, 16'd0, 16'd2, 16'd30};
				4: setting = '{16'd100, 16'd40, 16'd3, 16'd100};
				default: setting = '{16'($urandom_range(1, 1023)),
					16'($urandom_range(1, 120)), 16'($urandom_range(0, 10)),
					16'($urandom_range(10, 200))};
			endcase
			write_reg(REG_SAMPLE_RATE, setting[0]);
			write_reg(REG_WINDOW, setting[1]);
			write_reg(REG_MIN_BEAT, setting[2]);
			write_reg(REG_MAX_BEAT, setting[3]);
			cfg_we <= 0;
			calm = (p == 4);
			run_phase(150);
			settle();
		end
		calm = 0;

		if (errors == 0 && pending == 0)
			$display("SUCCESS");
		else
			$display("FAILURE");
		$finish;
	end

endmodule

// ----- sim.f -----
rtl/whr_pkg.sv
rtl/whr_ctrl.sv
rtl/whr_datapath.sv
rtl/windowed_heart_rate_from_accel.sv
bench/whr_checker.sv
bench/tb_top.sv
